[hdl/pcpa_pkg.sv]
`default_nettype none
package pcpa_pkg;

    // fixed field widths
    localparam int ADDR_W    = 22;
    localparam int STOP_W    = 23;
    localparam int CPU_IN_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = STOP_W;

    // parameter defaults
    localparam int CPUS_DEF       = 8;
    localparam int PAGES_DEF      = 1024;
    localparam int PAGE_BYTES_DEF = 4096;

    // register reset values
    localparam logic [ADDR_W-1:0] REGION_START_RST = '0;
    localparam logic [STOP_W-1:0] REGION_STOP_RST  = 23'h400000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_STOP  = 1'b1;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_ADDR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FREE,
        ST_FREE_WR,
        ST_OWN,
        ST_SCAN,
        ST_POP_RD,
        ST_POP_LINK,
        ST_POP_WR,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[hdl/per_cpu_page_free_list_allocator.sv]
// Sequence: a free checks the address, then pushes the page onto the requester's list (a bad
// address skips the push); an allocate pops from its own list or, when that is empty, scans the
// other lists, reads the head of the first non-empty one and pops it; all lists empty gives STAT_EMPTY.
// Flow: one item at a time, as the sequencer walks the head and link memories through their single
// registered read ports; in_stall stays high until the result is in the output register.
// Reset: asynchronous, all lists empty (non-empty flags cleared); memories not cleared.
`default_nettype none
module per_cpu_page_free_list_allocator
    import pcpa_pkg::*;
#(
    parameter int CPUS       = CPUS_DEF,       // 1..64
    parameter int PAGES      = PAGES_DEF,      // 2..1048576
    parameter int PAGE_BYTES = PAGE_BYTES_DEF  // power of two, 16..65536
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // request beats
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 command,
    input  wire logic [CPU_IN_W-1:0]  requester_cpu,
    input  wire logic [ADDR_W-1:0]    page_address,
    // result beats
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [STATUS_W-1:0]       status,
    output logic [ADDR_W-1:0]         result_address
);

    // index widths derived from the parameters
    localparam int CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int IDX_W  = $clog2(PAGES);
    localparam int LINK_W = $clog2(PAGES + 1);   // head/link: page index plus one, 0 = end
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int PGN_W  = ADDR_W - OFF_W;      // page number field of an address
    localparam int MOD_W  = 7;                   // holds CPUS up to 64

    // ------------------------------------------------------------------
    // storage
    // ------------------------------------------------------------------
    logic [LINK_W-1:0] heads_mem [CPUS];   // head of each list, valid only when flagged
    logic [LINK_W-1:0] links_mem [PAGES];  // next link per page, undefined until pushed

    logic [CPUS-1:0]   nonempty_reg, nonempty_next;

    logic [ADDR_W-1:0] region_start_reg;
    logic [STOP_W-1:0] region_stop_reg;

    state_t            state_reg, state_next;
    logic [CPU_W-1:0]  cpu_reg, cpu_next;      // requester after reduction modulo CPUS
    logic [CPU_W-1:0]  sel_reg, sel_next;      // list being read / written
    logic [CPU_W-1:0]  scan_reg, scan_next;    // steal scan pointer
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0]  page_reg, page_next;
    logic [LINK_W-1:0] head_rd_reg;
    logic [LINK_W-1:0] link_rd_reg;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   result_address_reg, result_address_next;

    // memory write controls
    logic              head_we;
    logic [LINK_W-1:0] head_wdata;
    logic              link_we;
    logic [LINK_W-1:0] link_wdata;
    logic [IDX_W-1:0]  link_raddr;

    // ------------------------------------------------------------------
    // requester reduced modulo CPUS by repeated subtraction (narrow)
    // ------------------------------------------------------------------
    logic [MOD_W-1:0] cpu_mod;
    always_comb
    begin
        cpu_mod = MOD_W'(requester_cpu);
        for (int k = 0; k < 8; k++)
        begin
            if (cpu_mod >= MOD_W'(CPUS))
                cpu_mod = cpu_mod - MOD_W'(CPUS);
        end
    end

    // ------------------------------------------------------------------
    // free address check on the latched address
    // ------------------------------------------------------------------
    logic [PGN_W-1:0] pgn;
    logic             addr_ok;
    assign pgn = addr_reg[ADDR_W-1:OFF_W];
    assign addr_ok = (addr_reg[OFF_W-1:0] == '0)
                  && (addr_reg >= region_start_reg)
                  && (STOP_W'(addr_reg) < region_stop_reg)
                  && (32'(pgn) < 32'(PAGES));

    // page index back to a byte address, cut to the address field
    logic [ADDR_W+IDX_W+OFF_W-1:0] page_bytes_wide;
    assign page_bytes_wide = {{ADDR_W{1'b0}}, page_reg, {OFF_W{1'b0}}};

    assign link_raddr = IDX_W'(head_rd_reg - LINK_W'(1));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next          = state_reg;
        cpu_next            = cpu_reg;
        sel_next            = sel_reg;
        scan_next           = scan_reg;
        addr_next           = addr_reg;
        page_next           = page_reg;
        nonempty_next       = nonempty_reg;
        res_status_next     = res_status_reg;
        res_addr_next       = res_addr_reg;
        out_valid_next      = out_valid_reg && out_stall;
        status_next         = status_reg;
        result_address_next = result_address_reg;
        head_we             = 1'b0;
        head_wdata          = '0;
        link_we             = 1'b0;
        link_wdata          = '0;
        in_stall            = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cpu_next  = CPU_W'(cpu_mod);
                    sel_next  = CPU_W'(cpu_mod);
                    addr_next = page_address;
                    state_next = (command == CMD_FREE) ? ST_FREE : ST_OWN;
                end
            end

            // head of sel is read at this edge
            ST_FREE:
            begin
                page_next = IDX_W'(pgn);
                if (addr_ok)
                    state_next = ST_FREE_WR;
                else
                begin
                    res_status_next = STAT_BAD_ADDR;
                    res_addr_next   = '0;
                    state_next      = ST_DONE;
                end
            end

            // push: link the page to the old head, page becomes head
            ST_FREE_WR:
            begin
                link_we    = 1'b1;
                link_wdata = nonempty_reg[sel_reg] ? head_rd_reg : '0;
                head_we    = 1'b1;
                head_wdata = LINK_W'(page_reg) + LINK_W'(1);
                nonempty_next[sel_reg] = 1'b1;
                res_status_next = STAT_OK;
                res_addr_next   = '0;
                state_next      = ST_DONE;
            end

            ST_OWN:
            begin
                if (nonempty_reg[sel_reg])
                    state_next = ST_POP_LINK;    // head read at this edge
                else
                begin
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end

            // steal: first non-empty other list, ascending; STAT_EMPTY if there is none
            ST_SCAN:
            begin
                if ((scan_reg != cpu_reg) && nonempty_reg[scan_reg])
                begin
                    sel_next   = scan_reg;
                    state_next = ST_POP_RD;
                end
                else if (scan_reg == CPU_W'(CPUS - 1))
                begin
                    res_status_next = STAT_EMPTY;
                    res_addr_next   = '0;
                    state_next      = ST_DONE;
                end
                else
                    scan_next = scan_reg + CPU_W'(1);
            end

            ST_POP_RD:
            begin
                state_next = ST_POP_LINK;
            end

            // head known; link of the head page is read at this edge
            ST_POP_LINK:
            begin
                page_next  = link_raddr;
                state_next = ST_POP_WR;
            end

            ST_POP_WR:
            begin
                head_we    = 1'b1;
                head_wdata = link_rd_reg;
                nonempty_next[sel_reg] = (link_rd_reg != '0);
                res_status_next = STAT_OK;
                res_addr_next   = page_bytes_wide[ADDR_W-1:0];
                state_next      = ST_DONE;
            end

            // hand over once the output register is free
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = res_status_reg;
                    result_address_next = res_addr_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            nonempty_reg     <= '0;
            out_valid_reg    <= 1'b0;
            region_start_reg <= REGION_START_RST;
            region_stop_reg  <= REGION_STOP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REGION_START: region_start_reg <= cfg_data[ADDR_W-1:0];
                    CFG_REGION_STOP:  region_stop_reg  <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cpu_reg            <= cpu_next;
        sel_reg            <= sel_next;
        scan_reg           <= scan_next;
        addr_reg           <= addr_next;
        page_reg           <= page_next;
        res_status_reg     <= res_status_next;
        res_addr_reg       <= res_addr_next;
        status_reg         <= status_next;
        result_address_reg <= result_address_next;
    end

    // head memory: one write, one registered read at sel
    always_ff @(posedge clk)
    begin
        if (head_we)
            heads_mem[sel_reg] <= head_wdata;
        head_rd_reg <= heads_mem[sel_reg];
    end

    // link memory: one write, one registered read at the head page
    always_ff @(posedge clk)
    begin
        if (link_we)
            links_mem[page_reg] <= link_wdata;
        link_rd_reg <= links_mem[link_raddr];
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_address = result_address_reg;

endmodule
`default_nettype wire
